// ===== hdl/nsq_pkg.sv =====
// Shared types, constants and the microcode program of the LCD nibble sequencer.
package nsq_pkg;

   localparam int UADDR_W = 5;

   typedef enum logic [2:0] {
      REQ_INIT  = 3'd0,
      REQ_CMD   = 3'd1,
      REQ_DATA  = 3'd2,
      REQ_POS   = 3'd3,
      REQ_CLEAR = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_STROBE_HALF = 3'd0,
      CSR_WRITE_SETTLE = 3'd1,
      CSR_CLEAR_SETTLE = 3'd2,
      CSR_INIT_GAP    = 3'd3,
      CSR_POWER_UP    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      NIB_CONST = 2'd0,
      NIB_HIGH  = 2'd1,
      NIB_LOW   = 2'd2
   } nib_sel_type;

   typedef enum logic [2:0] {
      AFT_ZERO        = 3'd0,
      AFT_INIT_GAP    = 3'd1,
      AFT_SHORT       = 3'd2,
      AFT_WRITE       = 3'd3,
      AFT_WRITE_GAP   = 3'd4,
      AFT_WRITE_CLEAR = 3'd5
   } after_sel_type;

   typedef struct packed {
      nib_sel_type   nib_sel;
      logic [3:0]    nib_const;
      logic          rs_req;
      logic          before_pwr;
      after_sel_type after_sel;
      logic          last;
   } ucode_word_type;

   typedef struct packed {
      logic [7:0]  strobe_half_us;
      logic [9:0]  write_settle_us;
      logic [13:0] clear_settle_us;
      logic [13:0] init_gap_us;
      logic [15:0] power_up_us;
   } csr_regs_type;

   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic [15:0] wait_before_us;
      logic [15:0] wait_after_us;
      logic        last;
   } rsp_item_type;

   localparam logic [7:0]  STROBE_HALF_RST  = 8'd15;
   localparam logic [9:0]  WRITE_SETTLE_RST = 10'd65;
   localparam logic [13:0] CLEAR_SETTLE_RST = 14'd2000;
   localparam logic [13:0] INIT_GAP_RST     = 14'd10000;
   localparam logic [15:0] POWER_UP_RST     = 16'd30000;
   localparam logic [15:0] INIT_SHORT_US    = 16'd150;
   localparam logic [7:0]  SET_DDRAM_CMD    = 8'h80;

   localparam logic [UADDR_W-1:0] ENTRY_INIT  = 5'd0;
   localparam logic [UADDR_W-1:0] ENTRY_BYTE  = 5'd12;
   localparam logic [UADDR_W-1:0] ENTRY_CLEAR = 5'd14;

   function automatic ucode_word_type uw(input nib_sel_type sel, input logic [3:0] nib,
                                         input logic rs, input logic pwr,
                                         input after_sel_type aft, input logic lst);
      ucode_word_type w;
      w.nib_sel    = sel;
      w.nib_const  = nib;
      w.rs_req     = rs;
      w.before_pwr = pwr;
      w.after_sel  = aft;
      w.last       = lst;
      return w;
   endfunction

   // Program: power-up init, one byte (command, data, position), clear plus home.
   function automatic ucode_word_type ucode_rom(input logic [UADDR_W-1:0] addr);
      ucode_word_type w;
      case (addr)
         5'd0:    w = uw(NIB_CONST, 4'h3, 1'b0, 1'b1, AFT_INIT_GAP,    1'b0);
         5'd1:    w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, AFT_SHORT,       1'b0);
         5'd2:    w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, AFT_ZERO,        1'b0);
         5'd3:    w = uw(NIB_CONST, 4'h2, 1'b0, 1'b0, AFT_INIT_GAP,    1'b0);
         5'd4:    w = uw(NIB_CONST, 4'h2, 1'b0, 1'b0, AFT_ZERO,        1'b0);
         5'd5:    w = uw(NIB_CONST, 4'h8, 1'b0, 1'b0, AFT_WRITE_GAP,   1'b0);
         5'd6:    w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, AFT_ZERO,        1'b0);
         5'd7:    w = uw(NIB_CONST, 4'h1, 1'b0, 1'b0, AFT_WRITE_GAP,   1'b0);
         5'd8:    w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, AFT_ZERO,        1'b0);
         5'd9:    w = uw(NIB_CONST, 4'hC, 1'b0, 1'b0, AFT_WRITE_GAP,   1'b0);
         5'd10:   w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, AFT_ZERO,        1'b0);
         5'd11:   w = uw(NIB_CONST, 4'h6, 1'b0, 1'b0, AFT_WRITE,       1'b1);
         5'd12:   w = uw(NIB_HIGH,  4'h0, 1'b1, 1'b0, AFT_ZERO,        1'b0);
         5'd13:   w = uw(NIB_LOW,   4'h0, 1'b1, 1'b0, AFT_WRITE,       1'b1);
         5'd14:   w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, AFT_ZERO,        1'b0);
         5'd15:   w = uw(NIB_CONST, 4'h1, 1'b0, 1'b0, AFT_WRITE_CLEAR, 1'b0);
         5'd16:   w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, AFT_ZERO,        1'b0);
         5'd17:   w = uw(NIB_CONST, 4'h2, 1'b0, 1'b0, AFT_WRITE_CLEAR, 1'b1);
         default: w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, AFT_ZERO,        1'b1);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/nsq_csr.sv =====
// Configuration register file of the LCD nibble sequencer.
module nsq_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output nsq_pkg::csr_regs_type regs
);

   nsq_pkg::csr_regs_type regs_ff, regs_in;

   assign csr_ready = 1'b1;
   assign regs      = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         case (nsq_pkg::csr_index_type'(csr_index))
            nsq_pkg::CSR_STROBE_HALF:  regs_in.strobe_half_us  = csr_data[7:0];
            nsq_pkg::CSR_WRITE_SETTLE: regs_in.write_settle_us = csr_data[9:0];
            nsq_pkg::CSR_CLEAR_SETTLE: regs_in.clear_settle_us = csr_data[13:0];
            nsq_pkg::CSR_INIT_GAP:     regs_in.init_gap_us     = csr_data[13:0];
            nsq_pkg::CSR_POWER_UP:     regs_in.power_up_us     = csr_data;
            default:                   regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.strobe_half_us  <= nsq_pkg::STROBE_HALF_RST;
         regs_ff.write_settle_us <= nsq_pkg::WRITE_SETTLE_RST;
         regs_ff.clear_settle_us <= nsq_pkg::CLEAR_SETTLE_RST;
         regs_ff.init_gap_us     <= nsq_pkg::INIT_GAP_RST;
         regs_ff.power_up_us     <= nsq_pkg::POWER_UP_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== hdl/nsq_datapath.sv =====
// Datapath: turn one control word plus request operands into a transfer item.
module nsq_datapath (
   input  nsq_pkg::ucode_word_type uword,
   input  logic [7:0]              byte_val,
   input  logic                    rs_val,
   input  nsq_pkg::csr_regs_type   regs,
   output nsq_pkg::rsp_item_type   item
);

   logic [15:0] write_us;
   logic [15:0] gap_us;
   logic [15:0] clear_us;

   assign write_us = {6'd0, regs.write_settle_us};
   assign gap_us   = {2'd0, regs.init_gap_us};
   assign clear_us = {2'd0, regs.clear_settle_us};

   always_comb begin
      case (uword.nib_sel)
         nsq_pkg::NIB_HIGH: item.nibble = byte_val[7:4];
         nsq_pkg::NIB_LOW:  item.nibble = byte_val[3:0];
         default:           item.nibble = uword.nib_const;
      endcase

      case (uword.after_sel)
         nsq_pkg::AFT_INIT_GAP:    item.wait_after_us = gap_us;
         nsq_pkg::AFT_SHORT:       item.wait_after_us = nsq_pkg::INIT_SHORT_US;
         nsq_pkg::AFT_WRITE:       item.wait_after_us = write_us;
         nsq_pkg::AFT_WRITE_GAP:   item.wait_after_us = write_us + gap_us;
         nsq_pkg::AFT_WRITE_CLEAR: item.wait_after_us = write_us + clear_us;
         default:                  item.wait_after_us = 16'd0;
      endcase

      item.reg_select     = uword.rs_req & rs_val;
      item.wait_before_us = uword.before_pwr ? regs.power_up_us : 16'd0;
      item.last           = uword.last;
   end

endmodule

// ===== hdl/nsq_sequencer.sv =====
// Microcode sequencer: dispatch, step counter and the result output register.
module nsq_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_kind,
   input  logic [7:0]            req_value,
   input  logic                  req_row,
   input  logic [5:0]            req_column,
   output nsq_pkg::ucode_word_type uword,
   output logic [7:0]            byte_val,
   output logic                  rs_val,
   input  nsq_pkg::rsp_item_type item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nsq_pkg::rsp_item_type rsp_item
);

   logic                         busy_ff, busy_in;
   logic [nsq_pkg::UADDR_W-1:0]  pc_ff, pc_in;
   logic [7:0]                   byte_ff, byte_in;
   logic                         rs_ff, rs_in;
   logic                         vld_ff, vld_in;
   nsq_pkg::rsp_item_type        item_ff, item_in;
   logic                         take;
   logic                         step;

   assign req_tready = ~busy_ff;
   assign take       = req_tvalid & ~busy_ff;
   assign step       = busy_ff & (~vld_ff | rsp_ready);
   assign uword      = nsq_pkg::ucode_rom(pc_ff);
   assign byte_val   = byte_ff;
   assign rs_val     = rs_ff;
   assign rsp_valid  = vld_ff;
   assign rsp_item   = item_ff;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      byte_in = byte_ff;
      rs_in   = rs_ff;
      vld_in  = vld_ff & ~rsp_ready;
      item_in = item_ff;

      if (take) begin
         byte_in = req_value;
         rs_in   = 1'b0;
         case (nsq_pkg::req_kind_type'(req_kind))
            nsq_pkg::REQ_INIT: begin
               busy_in = 1'b1;
               pc_in   = nsq_pkg::ENTRY_INIT;
            end
            nsq_pkg::REQ_CMD: begin
               busy_in = 1'b1;
               pc_in   = nsq_pkg::ENTRY_BYTE;
            end
            nsq_pkg::REQ_DATA: begin
               busy_in = 1'b1;
               pc_in   = nsq_pkg::ENTRY_BYTE;
               rs_in   = 1'b1;
            end
            nsq_pkg::REQ_POS: begin
               busy_in = 1'b1;
               pc_in   = nsq_pkg::ENTRY_BYTE;
               byte_in = nsq_pkg::SET_DDRAM_CMD | {1'b0, req_row, req_column};
            end
            nsq_pkg::REQ_CLEAR: begin
               busy_in = 1'b1;
               pc_in   = nsq_pkg::ENTRY_CLEAR;
            end
            default: busy_in = 1'b0;
         endcase
      end else if (step) begin
         vld_in  = 1'b1;
         item_in = item;
         pc_in   = pc_ff + 1'b1;
         busy_in = ~uword.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
      item_ff <= item_in;
   end

endmodule

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer for a 4-bit bus.
//
// Usage: send one request on req_* (tuser = kind, tdata = byte/row/column).
// The block expands it into a run of nibble transfers on rsp_*, one item per
// transfer, with tlast on the final transfer of the request. Each item carries
// the register-select level (tuser), the nibble and the microsecond waits
// before and after the enable strobe (tdata). Kinds: power-up init gives 12
// transfers, command, data and cursor position give 2, clear plus home gives
// 4; unknown kinds are taken and dropped without any transfer.
// Timing: a request is taken into the step counter and byte registers, then
// its transfers enter the output register one per cycle while the output is
// not stalled, each read from one step of the microcode program. The next
// request is taken as soon as the last transfer sits in the output register.
// Stalls: with a transfer waiting and rsp_tready low, hold the output register
// and freeze the step counter. Reset empties the output and loads the
// power-on register values. Write the csr_* port only while no request is in flight.
module char_lcd_nibble_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   input  logic [15:0] req_tdata,   // [7:0] value_byte, [8] row, [14:9] column, [15] zero
   // transfer channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] reg_select
   output logic [39:0] rsp_tdata,   // [3:0] nibble, [19:4] wait_before_us,
                                    // [35:20] wait_after_us, [39:36] zero
   output logic        rsp_tlast,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   nsq_pkg::csr_regs_type   regs;
   nsq_pkg::ucode_word_type uword;
   nsq_pkg::rsp_item_type   item;
   nsq_pkg::rsp_item_type   rsp_item;
   logic [7:0]              byte_val;
   logic                    rs_val;

   // Register file for the strobe, settle, init gap and power-up times.
   nsq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .regs      (regs)
   );

   // Step counter, dispatch on request kind and the output register.
   nsq_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_value  (req_tdata[7:0]),
      .req_row    (req_tdata[8]),
      .req_column (req_tdata[14:9]),
      .uword      (uword),
      .byte_val   (byte_val),
      .rs_val     (rs_val),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // Nibble select and wait sums driven by the current control word.
   nsq_datapath u_dp (
      .uword    (uword),
      .byte_val (byte_val),
      .rs_val   (rs_val),
      .regs     (regs),
      .item     (item)
   );

   // Pack the transfer, nibble in the lowest bits.
   assign rsp_tuser = rsp_item.reg_select;
   assign rsp_tlast = rsp_item.last;
   assign rsp_tdata = {4'd0, rsp_item.wait_after_us, rsp_item.wait_before_us,
                       rsp_item.nibble};

endmodule
